// ===== rtl/lkc_pkg.sv =====
// Shared types and fixed field widths for the LRU key cache.
package lkc_pkg;

   localparam int KeyW     = 64;
   localparam int RankW    = 3;
   localparam int OccW     = 4;
   localparam int CapW     = 4;
   localparam int CapReset = 5;

   // per-cell control from the top level
   typedef struct packed {
      logic step;   // access beat accepted this cycle
      logic valid;  // cell position is below the fill count
      logic last;   // cell holds the least recent valid entry
   } cell_ctrl_type;

endpackage

// ===== rtl/lkc_cell.sv =====
// One recency slot: holds a key, compares it, and takes its younger neighbor's key.
module lkc_cell #(
   parameter int KEY_BITS = 64
) (
   input  logic                  clock,
   input  lkc_pkg::cell_ctrl_type ctrl,
   input  logic [KEY_BITS-1:0]   search_key,
   input  logic [KEY_BITS-1:0]   prev_key,
   input  logic                  found_in,
   output logic                  found_out,
   output logic                  first_hit,
   output logic [KEY_BITS-1:0]   key_out,
   output logic [KEY_BITS-1:0]   evict_key
);
   import lkc_pkg::*;

   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] key_in;
   logic                match;

   assign match     = ctrl.valid && (key_ff == search_key);
   assign first_hit = match && !found_in;
   assign found_out = found_in || match;
   assign key_out   = key_ff;
   assign evict_key = ctrl.last ? key_ff : '0;

   // cells up to and including the first match (every cell on a miss) move down one place
   always_comb begin
      key_in = key_ff;
      if (ctrl.step && !found_in) begin
         key_in = prev_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// ===== rtl/lru_key_cache_unit.sv =====
// Fully associative LRU key cache built from a chain of recency cells.
// The result strobe rises in the cycle after the access beat is taken.
// Throughput: one access per cycle; busy never rises.
// Reset (synchronous, active high): cache empty, capacity min(5, ENTRIES), no result pending.
// The receiver cannot stall; results are never held back.
// Capacity writes are taken only while the cache is empty.
module lru_key_cache_unit #(
   parameter int ENTRIES  = 8,
   parameter int KEY_BITS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [lkc_pkg::KeyW-1:0]    req_key,
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic [lkc_pkg::RankW-1:0]   rsp_hit_rank,
   output logic                        rsp_evicted,
   output logic [lkc_pkg::KeyW-1:0]    rsp_evicted_key,
   output logic [lkc_pkg::OccW-1:0]    rsp_occupancy,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lkc_pkg::CapW-1:0]    csr_wdata
);
   import lkc_pkg::*;

   localparam int CW  = $clog2(ENTRIES + 1);
   localparam int IW  = $clog2(ENTRIES);
   localparam int CapInit = (CapReset > ENTRIES) ? ENTRIES : CapReset;

   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       cap_ff, cap_in;
   logic                valid_ff;
   logic                hit_ff, evicted_ff;
   logic [RankW-1:0]    rank_ff;
   logic [KeyW-1:0]     evkey_ff;
   logic [OccW-1:0]     occ_ff;

   logic                accept;
   logic [KEY_BITS-1:0] skey;
   cell_ctrl_type       ctrl [ENTRIES];
   logic [ENTRIES:0]    found;
   logic [ENTRIES-1:0]  first_hit;
   logic [KEY_BITS-1:0] keys [ENTRIES];
   logic [KEY_BITS-1:0] evk  [ENTRIES];
   logic [KEY_BITS-1:0] evict_or;
   logic [IW+2:0]       pos;
   logic                hit;
   logic                evict;
   logic [CW-1:0]       cnt_a;

   assign accept    = start && !busy;
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign skey      = req_key[KEY_BITS-1:0];
   assign found[0]  = 1'b0;

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         assign ctrl[g].step  = accept;
         assign ctrl[g].valid = CW'(g) < count_ff;
         assign ctrl[g].last  = (CW'(g + 1) == count_ff);

         lkc_cell #(.KEY_BITS(KEY_BITS)) u_cell (
            .clock      (clock),
            .ctrl       (ctrl[g]),
            .search_key (skey),
            .prev_key   ((g == 0) ? skey : keys[(g == 0) ? 0 : g - 1]),
            .found_in   (found[g]),
            .found_out  (found[g+1]),
            .first_hit  (first_hit[g]),
            .key_out    (keys[g]),
            .evict_key  (evk[g])
         );
      end
   endgenerate

   assign hit = found[ENTRIES];

   // encode the single first-match position and collect the tail key
   always_comb begin
      pos      = '0;
      evict_or = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (first_hit[i]) begin
            pos = pos | (IW+3)'(i);
         end
         evict_or = evict_or | evk[i];
      end
   end

   assign evict = !hit && (count_ff >= cap_ff) && (count_ff != '0);

   always_comb begin
      cnt_a    = evict ? count_ff - CW'(1) : count_ff;
      if (cnt_a >= CW'(ENTRIES)) begin
         cnt_a = CW'(ENTRIES - 1);
      end
      count_in = count_ff;
      if (accept && !hit) begin
         count_in = cnt_a + CW'(1);
      end
   end

   always_comb begin
      cap_in = cap_ff;
      if (csr_valid && csr_ready && (count_ff == '0)) begin
         if (csr_wdata == '0) begin
            cap_in = CW'(1);
         end else if (32'(csr_wdata) > ENTRIES) begin
            cap_in = CW'(ENTRIES);
         end else begin
            cap_in = CW'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CW'(CapInit);
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         cap_ff   <= cap_in;
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff     <= hit;
         rank_ff    <= pos[RankW-1:0];
         evicted_ff <= evict;
         evkey_ff   <= evict ? KeyW'(evict_or) : '0;
         occ_ff     <= OccW'(count_in);
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_hit_rank    = rank_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = evkey_ff;
   assign rsp_occupancy   = occ_ff;

endmodule

// ===== rtl/lkc_checker.sv =====
// Port-level checks for the LRU key cache, bound to the top level.
module lkc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic                      rsp_hit,
   input logic [lkc_pkg::RankW-1:0] rsp_hit_rank,
   input logic                      rsp_evicted,
   input logic [lkc_pkg::KeyW-1:0]  rsp_evicted_key
);
   import lkc_pkg::*;

   // each accepted beat gives exactly one result on the next cycle
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted beat gave no result");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("result without an accepted beat");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_evicted)
      else $error("hit reported an eviction");

   a_evkey_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted) |-> (rsp_evicted_key == '0))
      else $error("evicted key set without eviction");

   a_miss_rank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_hit_rank == '0))
      else $error("miss with nonzero rank");

endmodule

bind lru_key_cache_unit lkc_checker u_lkc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_hit         (rsp_hit),
   .rsp_hit_rank    (rsp_hit_rank),
   .rsp_evicted     (rsp_evicted),
   .rsp_evicted_key (rsp_evicted_key)
);
